@@ hdl/rcfr_pkg.sv @@
// ---------------------------------------------------------------------------
// rcfr_pkg
// Shared widths, register indexes, reset values and parameter defaults of
// the rc channel frame receiver.
// ---------------------------------------------------------------------------
package rcfr_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int CH_IDX_W  = 4;
    localparam int CFG_IDX_W = 8;

    // parameter defaults
    localparam int NUM_CH_DEF        = 16;
    localparam int CH_BITS_DEF       = 11;
    localparam int PAYLOAD_BYTES_DEF = 22;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CH_TYPE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = CFG_IDX_W'(3);

    // configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST = 8'hC8;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST   = 8'd64;
    localparam logic [BYTE_W-1:0] CH_TYPE_RST   = 8'd22;
    localparam logic [BYTE_W-1:0] CRC_POLY_RST  = 8'hD5;

endpackage

@@ hdl/rcfr_if.sv @@
// ---------------------------------------------------------------------------
// rcfr interfaces
// Valid/ready channels of the rc channel frame receiver: received bytes,
// unpacked channel words and configuration writes.
// ---------------------------------------------------------------------------

// received serial bytes
interface rcfr_byte_if import rcfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, rx_byte, input ready);
    modport sink   (input valid, rx_byte, output ready);
endinterface

// unpacked channel words
interface rcfr_ch_if import rcfr_pkg::*; #(
    parameter int CH_BITS = CH_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic [CH_IDX_W-1:0] channel_index;
    logic [CH_BITS-1:0]  channel_value;
    logic                last_channel;

    modport source (output valid, channel_index, channel_value, last_channel,
                    input ready);
    modport sink   (input valid, channel_index, channel_value, last_channel,
                    output ready);
endinterface

// configuration register writes
interface rcfr_cfg_if import rcfr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rc_channel_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// rc_channel_frame_receiver
// Hunts for framed rc channel packets in a byte stream, checks the CRC-8
// over type and payload, and unpacks a good channel frame LSB-first into
// NUM_CH channel words of CH_BITS bits each.
// ---------------------------------------------------------------------------
//  port    dir   word                                  handshake
//  i_rx    in    rx_byte                               valid/ready
//  o_ch    out   channel_index, channel_value, last    valid/ready
//  i_cfg   in    index, data                           valid/ready, always ready
//
//  While a frame is received one byte is taken every cycle.
//  A good channel frame then unpacks from the payload memory (one read port):
//  each payload byte is read and merged into the bit buffer before the next
//  read, and each channel word is emitted in turn; i_rx is held off until the
//  last channel word is emitted. A stalled o_ch holds the unpacker.
//  Reset is synchronous; the payload memory is not cleared.
// ---------------------------------------------------------------------------
module rc_channel_frame_receiver import rcfr_pkg::*; #(
    parameter int NUM_CH        = NUM_CH_DEF,
    parameter int CH_BITS       = CH_BITS_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcfr_byte_if.sink  i_rx,
    rcfr_ch_if.source  o_ch,
    rcfr_cfg_if.sink   i_cfg
);

    localparam int AW    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CW    = $clog2(PAYLOAD_BYTES + 1);
    localparam int ACC_W = CH_BITS + BYTE_W - 1;
    localparam int ACW   = $clog2(ACC_W + 1);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_TYPE = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    // one crc-8 byte update, msb first
    function automatic logic [BYTE_W-1:0] f_crc8(
        input logic [BYTE_W-1:0] c,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] p
    );
        logic [BYTE_W-1:0] v;
        v = c ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            v = v[BYTE_W-1] ? ({v[BYTE_W-2:0], 1'b0} ^ p) : {v[BYTE_W-2:0], 1'b0};
        end
        return v;
    endfunction

    // configuration registers
    logic [BYTE_W-1:0] r_sync_byte;
    logic [BYTE_W-1:0] r_max_len;
    logic [BYTE_W-1:0] r_ch_type;
    logic [BYTE_W-1:0] r_crc_poly;

    // frame parser state
    logic [1:0]        r_phase;
    logic [BYTE_W-1:0] r_frame_len;
    logic [BYTE_W-1:0] r_byte_count;
    logic [BYTE_W-1:0] r_crc;
    logic [BYTE_W-1:0] r_frame_kind;

    // unpacker state
    logic                r_busy;
    logic [CW-1:0]       r_rd_addr;
    logic                r_rd_pend;
    logic                r_rd_zero;
    logic [BYTE_W-1:0]   r_rd_data;
    logic [ACC_W-1:0]    r_acc;
    logic [ACW-1:0]      r_acc_cnt;
    logic [CH_IDX_W-1:0] r_ch_cnt;

    // output register
    logic                r_out_valid;
    logic [CH_IDX_W-1:0] r_out_index;
    logic [CH_BITS-1:0]  r_out_value;
    logic                r_out_last;

    // payload memory
    logic [BYTE_W-1:0] mem [PAYLOAD_BYTES];

    logic              rx_acc;
    logic [BYTE_W-1:0] rx_b;
    logic [BYTE_W-1:0] n_crc;
    logic              body_more;
    logic              frame_good;
    logic              wr_en;
    logic              rd_en;
    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] fetched;

    assign i_rx.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign rx_acc      = i_rx.valid && !r_busy;
    assign rx_b        = i_rx.rx_byte;

    assign n_crc      = f_crc8(r_crc, rx_b, r_crc_poly);
    assign body_more  = ({1'b0, r_byte_count} + 9'd2) < {1'b0, r_frame_len};
    assign frame_good = (r_frame_kind == r_ch_type)
                     && (r_frame_len == BYTE_W'(PAYLOAD_BYTES + 2))
                     && (rx_b == r_crc);
    assign wr_en      = rx_acc && (r_phase == PH_BODY) && body_more
                     && (r_byte_count < BYTE_W'(PAYLOAD_BYTES));

    assign out_free = !r_out_valid || o_ch.ready;
    assign rd_en    = r_busy && !r_rd_pend && (r_acc_cnt < ACW'(CH_BITS))
                   && (r_rd_addr < CW'(PAYLOAD_BYTES));
    assign emit     = r_busy && !r_rd_pend && (r_acc_cnt >= ACW'(CH_BITS)) && out_free;
    assign fetched  = r_rd_zero ? '0 : r_rd_data;

    assign o_ch.valid         = r_out_valid;
    assign o_ch.channel_index = r_out_index;
    assign o_ch.channel_value = r_out_value;
    assign o_ch.last_channel  = r_out_last;

    // payload memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_byte_count[AW-1:0]] <= rx_b;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_addr[AW-1:0]];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_BYTE_RST;
            r_max_len   <= MAX_LEN_RST;
            r_ch_type   <= CH_TYPE_RST;
            r_crc_poly  <= CRC_POLY_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SYNC_BYTE: r_sync_byte <= i_cfg.data;
                REG_MAX_LEN:   r_max_len   <= i_cfg.data;
                REG_CH_TYPE:   r_ch_type   <= i_cfg.data;
                REG_CRC_POLY:  r_crc_poly  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // frame parser and unpacker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_frame_len  <= '0;
            r_byte_count <= '0;
            r_crc        <= '0;
            r_frame_kind <= '0;
            r_busy       <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_rd_addr    <= '0;
            r_acc        <= '0;
            r_acc_cnt    <= '0;
            r_ch_cnt     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_ch.ready && !emit) begin
                r_out_valid <= 1'b0;
            end

            if (rx_acc) begin
                case (r_phase)
                    PH_HUNT: begin
                        if (rx_b == r_sync_byte) begin
                            r_phase <= PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (rx_b != '0 && rx_b < r_max_len) begin
                            r_frame_len <= rx_b;
                            r_phase     <= PH_TYPE;
                        end else begin
                            r_phase <= PH_HUNT;
                        end
                    end
                    PH_TYPE: begin
                        r_frame_kind <= rx_b;
                        r_crc        <= f_crc8('0, rx_b, r_crc_poly);
                        r_byte_count <= '0;
                        r_phase      <= (r_frame_len >= 8'd2) ? PH_BODY : PH_HUNT;
                    end
                    PH_BODY: begin
                        if (body_more) begin
                            r_crc        <= n_crc;
                            r_byte_count <= r_byte_count + 8'd1;
                        end else begin
                            r_phase <= PH_HUNT;
                            // start unpacking a confirmed channel frame
                            if (frame_good) begin
                                r_busy    <= 1'b1;
                                r_rd_addr <= '0;
                                r_rd_pend <= 1'b0;
                                r_acc     <= '0;
                                r_acc_cnt <= '0;
                                r_ch_cnt  <= '0;
                            end
                        end
                    end
                    default: r_phase <= PH_HUNT;
                endcase
            end

            if (r_busy) begin
                if (r_rd_pend) begin
                    // merge the fetched byte above the bits held
                    r_acc     <= r_acc | (ACC_W'(fetched) << r_acc_cnt);
                    r_acc_cnt <= r_acc_cnt + ACW'(BYTE_W);
                    r_rd_pend <= 1'b0;
                end else if (r_acc_cnt < ACW'(CH_BITS)) begin
                    // fetch next payload byte, zeros past the end
                    r_rd_pend <= 1'b1;
                    r_rd_zero <= !(r_rd_addr < CW'(PAYLOAD_BYTES));
                    if (r_rd_addr < CW'(PAYLOAD_BYTES)) begin
                        r_rd_addr <= r_rd_addr + CW'(1);
                    end
                end else if (out_free) begin
                    // emit one channel word
                    r_out_valid <= 1'b1;
                    r_out_index <= r_ch_cnt;
                    r_out_value <= r_acc[CH_BITS-1:0];
                    r_out_last  <= (r_ch_cnt == CH_IDX_W'(NUM_CH - 1));
                    r_acc       <= r_acc >> CH_BITS;
                    r_acc_cnt   <= r_acc_cnt - ACW'(CH_BITS);
                    r_ch_cnt    <= r_ch_cnt + CH_IDX_W'(1);
                    if (r_ch_cnt == CH_IDX_W'(NUM_CH - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    // last word carries the top channel number
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_index == CH_IDX_W'(NUM_CH - 1))
        else $error("last channel flag on wrong channel");

    // one memory read outstanding at a time
    a_one_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |=> !r_rd_pend)
        else $error("back to back payload reads");

    // bit buffer never overflows
    a_acc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_acc_cnt <= ACW'(ACC_W))
        else $error("unpack buffer overflow");

    // unpacking starts only on the crc byte of a body
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(rx_acc) && $past(r_phase) == PH_BODY)
        else $error("unpack started outside a frame end");

endmodule
